### hw/rtl/ogm_pkg.sv
// Shared types and constants for the occupancy grid merge block.
package ogm_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COORD_W    = 8;
  localparam int DIM_W      = 9;
  localparam int SHIFT_W    = 10;
  localparam int CELL_W     = 8;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  localparam logic [CELL_W-1:0] UNKNOWN_CELL = 8'hFF;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_MERGE = 2'd1,
    ACT_READ  = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH     = 3'd0,
    REG_GRID_HEIGHT    = 3'd1,
    REG_SHIFT_X        = 3'd2,
    REG_SHIFT_Y        = 3'd3,
    REG_OVERWRITE_MODE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]               action;
    logic [COORD_W-1:0]       col;
    logic [COORD_W-1:0]       row;
    logic signed [CELL_W-1:0] cell_value;
  } req_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] stored_value;
    logic                     was_written;
    logic                     in_bounds;
  } res_t;

  typedef struct packed {
    logic [DIM_W-1:0]          grid_width;
    logic [DIM_W-1:0]          grid_height;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
    logic                      overwrite_mode;
  } cfg_t;

endpackage

### hw/rtl/occupancy_grid_greedy_merge.sv
// Top level of the occupancy grid merge block.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | req_data (req_t)
//   res     | out       | res_valid, res_stall | res_data (res_t)
//   cfg     | in        | APB psel/penable     | paddr, pwdata, prdata
//
// One request per cycle while req_stall is low; a result is registered in stage s1, then in
// the result register. The grid memory is read on acceptance and written back as s1 moves on;
// a write to the same cell on the edge of that read is forwarded.
// Reset clears control and configuration registers only; grid cells are undefined until written.
// A stalled result holds the pipeline; the request side stalls while both stages are full and stalled.
module occupancy_grid_greedy_merge import ogm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req_data,
  output logic               res_valid,
  input  logic               res_stall,
  output res_t               res_data
);

  cfg_t cfg;

  ogm_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ogm_merge_core u_merge_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

### hw/rtl/ogm_cfg_regs.sv
// APB-style configuration register file.
module ogm_cfg_regs import ogm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width     <= DIM_W'(MAX_WIDTH);
      cfg.grid_height    <= DIM_W'(MAX_HEIGHT);
      cfg.shift_x        <= '0;
      cfg.shift_y        <= '0;
      cfg.overwrite_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_GRID_WIDTH:     cfg.grid_width     <= pwdata[DIM_W-1:0];
        REG_GRID_HEIGHT:    cfg.grid_height    <= pwdata[DIM_W-1:0];
        REG_SHIFT_X:        cfg.shift_x        <= $signed(pwdata[SHIFT_W-1:0]);
        REG_SHIFT_Y:        cfg.shift_y        <= $signed(pwdata[SHIFT_W-1:0]);
        REG_OVERWRITE_MODE: cfg.overwrite_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_GRID_WIDTH:     prdata = {{(PDATA_W-DIM_W){1'b0}}, cfg.grid_width};
      REG_GRID_HEIGHT:    prdata = {{(PDATA_W-DIM_W){1'b0}}, cfg.grid_height};
      REG_SHIFT_X:        prdata = {{(PDATA_W-SHIFT_W){cfg.shift_x[SHIFT_W-1]}}, cfg.shift_x};
      REG_SHIFT_Y:        prdata = {{(PDATA_W-SHIFT_W){cfg.shift_y[SHIFT_W-1]}}, cfg.shift_y};
      REG_OVERWRITE_MODE: prdata = {{(PDATA_W-1){1'b0}}, cfg.overwrite_mode};
      default:            prdata = '0;
    endcase
  end

endmodule

### hw/rtl/ogm_merge_core.sv
// Grid memory with read-modify-write pipeline, forwarding and result register.
module ogm_merge_core import ogm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic res_valid,
  input  logic res_stall,
  output res_t res_data
);

  logic [CELL_W-1:0] grid_mem [0:(1<<ADDR_W)-1];

  logic                      req_fire;
  logic signed [SHIFT_W-1:0] off_x;
  logic signed [SHIFT_W-1:0] off_y;
  logic signed [SHIFT_W:0]   tx;
  logic signed [SHIFT_W:0]   ty;
  logic [DIM_W-1:0]          w_lim;
  logic [DIM_W-1:0]          h_lim;
  logic                      inb;
  logic [ADDR_W-1:0]         addr;

  logic                      s1_valid;
  logic                      s1_fire;
  logic [ADDR_W-1:0]         s1_addr;
  logic                      s1_inb;
  logic [1:0]                s1_action;
  logic [CELL_W-1:0]         s1_val;
  logic [CELL_W-1:0]         rdata;
  logic                      fwd_hit;
  logic [CELL_W-1:0]         fwd_data;
  logic [CELL_W-1:0]         cur;
  logic                      s1_wr;
  res_t                      s1_res;

  assign req_fire  = req_valid && !req_stall;
  assign s1_fire   = s1_valid && (!res_valid || !res_stall);
  assign req_stall = s1_valid && !s1_fire;

  // target cell and bounds
  always_comb begin
    off_x = (req_data.action == ACT_MERGE) ? cfg.shift_x : '0;
    off_y = (req_data.action == ACT_MERGE) ? cfg.shift_y : '0;
    tx = $signed({{(SHIFT_W+1-COORD_W){1'b0}}, req_data.col}) + $signed({off_x[SHIFT_W-1], off_x});
    ty = $signed({{(SHIFT_W+1-COORD_W){1'b0}}, req_data.row}) + $signed({off_y[SHIFT_W-1], off_y});
    w_lim = (cfg.grid_width  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : cfg.grid_width;
    h_lim = (cfg.grid_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg.grid_height;
    inb = !tx[SHIFT_W] && (tx[SHIFT_W-1:0] < {1'b0, w_lim})
       && !ty[SHIFT_W] && (ty[SHIFT_W-1:0] < {1'b0, h_lim});
    addr = {ty[COORD_W-1:0], tx[COORD_W-1:0]};
  end

  // modify: forwarded value covers a write landing on the same edge as the read
  always_comb begin
    cur   = fwd_hit ? fwd_data : rdata;
    s1_wr = 1'b0;
    if (s1_inb) begin
      if (s1_action == ACT_LOAD) begin
        s1_wr = 1'b1;
      end else if (s1_action == ACT_MERGE) begin
        s1_wr = (cur == UNKNOWN_CELL)
             || (cfg.overwrite_mode && (s1_val != UNKNOWN_CELL) && (s1_val != cur));
      end
    end
    s1_res.stored_value = !s1_inb ? '0 : $signed(s1_wr ? s1_val : cur);
    s1_res.was_written  = s1_wr;
    s1_res.in_bounds    = s1_inb;
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rdata <= grid_mem[addr];
    end
    if (s1_fire && s1_wr) begin
      grid_mem[s1_addr] <= s1_val;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_addr   <= addr;
      s1_inb    <= inb;
      s1_action <= req_data.action;
      s1_val    <= req_data.cell_value;
      fwd_hit   <= s1_fire && s1_wr && (s1_addr == addr);
      fwd_data  <= s1_val;
    end
    if (s1_fire) begin
      res_data <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (req_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

### test/tb_top.sv
// Self-checking testbench: random and directed grid requests against an in-bench grid model.
`timescale 1ns / 1ps

module tb_top;
  import ogm_pkg::*;

  localparam logic [1:0] ACT_READ_ALT = 2'd3;
  localparam int LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;

  occupancy_grid_greedy_merge dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // grid settings as seen by the model
  int g_w = 256;
  int g_h = 256;
  int g_sx = 0;
  int g_sy = 0;
  bit g_ow = 1'b0;

  logic [CELL_W-1:0] grid_cells [0:MAX_WIDTH*MAX_HEIGHT-1];
  bit loaded_cell [0:MAX_WIDTH*MAX_HEIGHT-1];
  int unsigned loaded_list[$];

  req_t todo_req[$];
  res_t pending_res[$];
  int mism_cnt = 0;
  int cyc = 0;
  bit calm = 1'b0;
  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;

  task automatic report(string what);
    $display("MISMATCH: %s", what);
    mism_cnt++;
  endtask

  function automatic bit cell_target(logic [1:0] act, int c, int r, output int tx,
                                     output int ty);
    int ew, eh;
    ew = (g_w > MAX_WIDTH) ? MAX_WIDTH : g_w;
    eh = (g_h > MAX_HEIGHT) ? MAX_HEIGHT : g_h;
    tx = c;
    ty = r;
    if (act == ACT_MERGE) begin
      tx += g_sx;
      ty += g_sy;
    end
    return tx >= 0 && tx < ew && ty >= 0 && ty < eh;
  endfunction

  function automatic res_t merge_cell(req_t q);
    int tx, ty;
    int unsigned a;
    logic [CELL_W-1:0] cur;
    bit wr;
    res_t o;
    o = '0;
    if (cell_target(q.action, q.col, q.row, tx, ty)) begin
      a = ty * MAX_WIDTH + tx;
      cur = grid_cells[a];
      wr = 1'b0;
      if (q.action == ACT_LOAD)
        wr = 1'b1;
      else if (q.action == ACT_MERGE)
        wr = (cur == UNKNOWN_CELL) ||
             (g_ow && q.cell_value != UNKNOWN_CELL && q.cell_value != cur);
      if (wr) begin
        grid_cells[a] = q.cell_value;
        cur = q.cell_value;
      end
      o.stored_value = cur;
      o.was_written = wr;
      o.in_bounds = 1'b1;
    end
    return o;
  endfunction

  // a read or merge must never touch a cell that was never loaded
  function automatic bit safe_target(logic [1:0] act, int c, int r);
    int tx, ty;
    if (!cell_target(act, c, r, tx, ty))
      return 1'b1;
    return loaded_cell[ty * MAX_WIDTH + tx];
  endfunction

  function automatic void push_req(logic [1:0] act, int c, int r, logic [7:0] v);
    req_t q;
    int tx, ty;
    int unsigned a;
    q.action = act;
    q.col = c[7:0];
    q.row = r[7:0];
    q.cell_value = v;
    if (act == ACT_LOAD && cell_target(act, c, r, tx, ty)) begin
      a = ty * MAX_WIDTH + tx;
      if (!loaded_cell[a]) begin
        loaded_cell[a] = 1'b1;
        loaded_list.push_back(a);
      end
    end
    todo_req.push_back(q);
  endfunction

  function automatic logic [7:0] rand_cell();
    int k;
    k = $urandom_range(9);
    case (k)
      0, 1, 2: return UNKNOWN_CELL;
      3: return 8'h7F;
      4: return 8'h80;
      5: return 8'h00;
      6: return 8'($urandom_range(3, 1));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_random();
    int pick, c, r, k, tx, ty, ew, eh;
    int unsigned a;
    logic [1:0] act;
    logic [7:0] v;
    bit found;
    pick = $urandom_range(99);
    v = rand_cell();
    if (pick < 40) act = ACT_LOAD;
    else if (pick < 75) act = ACT_MERGE;
    else if (pick < 95) act = ACT_READ;
    else act = ACT_READ_ALT;
    if (act == ACT_LOAD) begin
      ew = (g_w > 255) ? 255 : g_w;
      eh = (g_h > 255) ? 255 : g_h;
      if ($urandom_range(99) < 70) begin
        c = $urandom_range(ew);
        r = $urandom_range(eh);
      end else begin
        c = $urandom_range(255);
        r = $urandom_range(255);
      end
      push_req(act, c, r, v);
      return;
    end
    found = 1'b0;
    if (loaded_list.size() != 0 && $urandom_range(99) < 85) begin
      a = loaded_list[$urandom_range(loaded_list.size() - 1)];
      tx = a % MAX_WIDTH;
      ty = a / MAX_WIDTH;
      c = tx;
      r = ty;
      if (act == ACT_MERGE) begin
        c = tx - g_sx;
        r = ty - g_sy;
      end
      found = c >= 0 && c <= 255 && r >= 0 && r <= 255;
    end
    for (k = 0; k < 8 && !found; k++) begin
      c = $urandom_range(255);
      r = $urandom_range(255);
      found = safe_target(act, c, r);
    end
    if (!found)
      act = ACT_LOAD;
    push_req(act, c, r, v);
  endfunction

  task automatic cfg_write(reg_idx_t idx, logic [PDATA_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GRID_WIDTH: g_w = v[8:0];
      REG_GRID_HEIGHT: g_h = v[8:0];
      REG_SHIFT_X: g_sx = int'($signed(v[9:0]));
      REG_SHIFT_Y: g_sy = int'($signed(v[9:0]));
      REG_OVERWRITE_MODE: g_ow = v[0];
      default: ;
    endcase
  endtask

  task automatic set_grid(int w, int h, int sx, int sy, bit ow);
    cfg_write(REG_GRID_WIDTH, PDATA_W'(w) & 32'h1FF);
    cfg_write(REG_GRID_HEIGHT, PDATA_W'(h) & 32'h1FF);
    cfg_write(REG_SHIFT_X, PDATA_W'(sx) & 32'h3FF);
    cfg_write(REG_SHIFT_Y, PDATA_W'(sy) & 32'h3FF);
    cfg_write(REG_OVERWRITE_MODE, PDATA_W'(ow));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (todo_req.size() != 0 || req_valid || pending_res.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(int n, bit hold);
    repeat (n) add_random();
    if (hold)
      hold_asked++;
    wait_drained();
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (todo_req.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
        req_valid <= 1'b1;
        req_data <= todo_req.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall)
      pending_res.push_back(merge_cell(req_data));
  end

  // long result hold, counted in cycles
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_done != hold_asked) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_asked;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result checker and stall generator
  always @(posedge clk) begin
    res_t want;
    bit stall_nxt;
    if (!rst && res_valid && !res_stall) begin
      if (pending_res.size() == 0) begin
        report($sformatf("unexpected result %p", res_data));
      end else begin
        want = pending_res.pop_front();
        if (res_data.stored_value !== want.stored_value)
          report($sformatf("stored_value got %0d want %0d",
                           res_data.stored_value, want.stored_value));
        if (res_data.was_written !== want.was_written)
          report($sformatf("was_written got %b want %b",
                           res_data.was_written, want.was_written));
        if (res_data.in_bounds !== want.in_bounds)
          report($sformatf("in_bounds got %b want %b",
                           res_data.in_bounds, want.in_bounds));
      end
    end
    if (rst) begin
      stall_nxt = 1'b0;
    end else if (hold_left > 0) begin
      stall_nxt = 1'b1;
    end else begin
      stall_nxt = !calm && $urandom_range(99) < 16;
    end
    res_stall <= stall_nxt;
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    set_grid(256, 256, 0, 0, 1'b0);
    push_req(ACT_LOAD, 0, 0, 8'h7F);
    push_req(ACT_LOAD, 255, 255, 8'h80);
    push_req(ACT_LOAD, 255, 0, UNKNOWN_CELL);
    push_req(ACT_LOAD, 0, 255, UNKNOWN_CELL);
    push_req(ACT_READ, 0, 0, 8'h55);
    push_req(ACT_READ, 255, 255, 8'hAA);
    push_req(ACT_READ_ALT, 255, 0, 8'h00);
    push_req(ACT_MERGE, 255, 0, 8'd5);
    push_req(ACT_MERGE, 0, 255, UNKNOWN_CELL);
    push_req(ACT_MERGE, 0, 0, 8'd3);
    // same cell back to back: exercises write-back forwarding
    push_req(ACT_LOAD, 1, 1, UNKNOWN_CELL);
    push_req(ACT_MERGE, 1, 1, UNKNOWN_CELL);
    push_req(ACT_LOAD, 1, 1, 8'd9);
    push_req(ACT_MERGE, 1, 1, UNKNOWN_CELL);
    push_req(ACT_READ, 1, 1, 8'hFF);
    wait_drained();

    set_grid(256, 256, 0, 0, 1'b1);
    push_req(ACT_MERGE, 1, 1, 8'd20);
    push_req(ACT_MERGE, 1, 1, 8'd20);
    wait_drained();

    set_grid(0, 256, 0, 0, 1'b1);
    push_req(ACT_LOAD, 0, 0, 8'd1);
    push_req(ACT_READ, 0, 0, 8'd0);
    wait_drained();

    set_grid(256, 0, 0, 0, 1'b1);
    push_req(ACT_MERGE, 0, 0, 8'd1);
    wait_drained();

    set_grid(511, 511, 511, -512, 1'b1);
    push_req(ACT_LOAD, 255, 255, UNKNOWN_CELL);
    push_req(ACT_MERGE, 0, 255, 8'd4);
    push_req(ACT_READ, 255, 255, 8'd0);
    wait_drained();

    set_grid(256, 256, 0, 0, 1'b0);
    run_random(300, 1'b0);
    set_grid(16, 12, 3, -2, 1'b1);
    run_random(250, 1'b1);
    set_grid(1, 1, 0, 0, 1'b1);
    run_random(100, 1'b0);
    calm = 1'b1;
    set_grid(200, 256, -40, 17, 1'b1);
    run_random(300, 1'b0);
    calm = 1'b0;
    set_grid(256, 256, -512, 511, 1'b0);
    run_random(100, 1'b0);
    set_grid(300, 100, 5, 0, 1'b0);
    run_random(200, 1'b0);
    set_grid(256, 256, -1, 1, 1'b1);
    run_random(420, 1'b0);

    repeat (8) @(negedge clk);
    if (pending_res.size() != 0)
      report($sformatf("%0d results never arrived", pending_res.size()));
    if (mism_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
hw/rtl/ogm_pkg.sv
hw/rtl/ogm_cfg_regs.sv
hw/rtl/ogm_merge_core.sv
hw/rtl/occupancy_grid_greedy_merge.sv
test/tb_top.sv
